// ===== src/lzw_stream_compressor_assert.svh =====
// assertion macros for the lzw stream compressor checker
// expects clk and rst_n to be visible where the macros are used
`ifndef LZW_STREAM_COMPRESSOR_ASSERT_SVH
`define LZW_STREAM_COMPRESSOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LZW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzw check failed");

// next-cycle implication, disabled during reset
`define LZW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzw check failed");

`endif

// ===== src/lzwsc_pkg.sv =====
// shared types, constants and the phrase emit function
// no dependencies
package lzwsc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } out_item_t;

    // head of the queue between front and back
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } qhead_t;

    localparam int CODE_W   = 22;
    localparam int PARENT_W = 23;
    localparam int KEY_W    = PARENT_W + 8;

    localparam logic [CODE_W-1:0]   CODE_CEILING     = 22'h3FFFFF;
    localparam logic [PARENT_W-1:0] LITERAL_PARENT   = 23'h400000;
    localparam logic [CODE_W-1:0]   SHORT_CODE_LIMIT = 22'd16383;
    localparam logic [31:0]         HASH_MULT        = 32'h9E3779B1;
    localparam logic [23:0]         LONG_MARK        = 24'hC00000;
    localparam logic [15:0]         SHORT_MARK       = 16'h8000;

    // phrase length classes
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_ONE  = 2'd1;
    localparam logic [1:0] CLS_TWO  = 2'd2;
    localparam logic [1:0] CLS_LONG = 2'd3;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } emit_t;

    function automatic emit_t phrase_bytes(input logic [1:0] cls, input logic [7:0] fc,
                                           input logic [7:0] sc,
                                           input logic [CODE_W-1:0] code);
        emit_t      e;
        logic [23:0] v24;
        logic [15:0] v16;
        e   = '0;
        v24 = LONG_MARK | {2'b00, code & CODE_CEILING};
        v16 = SHORT_MARK | code[15:0];
        if (cls != CLS_LONG)
        begin
            e.b[0] = fc;
            e.b[1] = sc;
            e.n    = (cls == CLS_TWO) ? 2'd2 : 2'd1;
        end
        else if (code > SHORT_CODE_LIMIT)
        begin
            e.b[0] = v24[23:16];
            e.b[1] = v24[15:8];
            e.b[2] = v24[7:0];
            e.n    = 2'd3;
        end
        else
        begin
            e.b[0] = v16[15:8];
            e.b[1] = v16[7:0];
            e.n    = 2'd2;
        end
        return e;
    endfunction

endpackage

// ===== src/lzwsc_chan_if.sv =====
// valid/ready channel carrying one payload item
// payload type set per instance, types from lzwsc_pkg
interface lzwsc_chan_if #(parameter type T = logic [0:0]);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/lzwsc_hash.sv =====
// multiplicative hash with a reciprocal-multiply modulo by the slot count
// depends on lzwsc_pkg
module lzwsc_hash #(
    parameter int HASH_SLOTS = 131072
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lzwsc_pkg::KEY_W-1:0]   key,
    output logic                          done,
    output logic [$clog2(HASH_SLOTS)-1:0] slot
);
    import lzwsc_pkg::*;

    localparam int SLOT_W = $clog2(HASH_SLOTS);
    // floor(2^32 / slots): the quotient estimate falls short by at most one
    localparam logic [23:0] RECIP   = 24'(64'h1_0000_0000 / 64'(HASH_SLOTS));
    localparam logic [23:0] DIVISOR = 24'(HASH_SLOTS);
    localparam logic [31:0] DIV32   = 32'(HASH_SLOTS);

    logic [31:0]       prod_reg, prod_next;
    logic [23:0]       quot_reg, quot_next;
    logic [31:0]       rem_reg, rem_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [3:0]        stage_reg, stage_next;
    logic [55:0]       recip_prod;
    logic [31:0]       back_prod;

    // quotient estimate, then remainder, then one correcting subtract
    assign recip_prod = 56'(prod_reg) * 56'(RECIP);
    assign back_prod  = 32'(quot_reg) * 32'(DIVISOR);

    always_comb
    begin
        logic [31:0] r1;
        prod_next  = start ? ({1'b0, key} * HASH_MULT) : prod_reg;
        quot_next  = recip_prod[55:32];
        rem_next   = prod_reg - back_prod;
        r1         = (rem_reg >= DIV32) ? (rem_reg - DIV32) : rem_reg;
        slot_next  = r1[SLOT_W-1:0];
        stage_next = {stage_reg[2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        slot_reg <= slot_next;
    end

    assign done = stage_reg[3];
    assign slot = slot_reg;
endmodule

// ===== src/lzwsc_front.sv =====
// input side: accepts items into a two-entry queue
// depends on lzwsc_pkg and lzwsc_chan_if
module lzwsc_front (
    input  logic              clk,
    input  logic              rst_n,
    lzwsc_chan_if.sink        data_chan,
    input  logic              hold,
    input  logic              pop,
    output lzwsc_pkg::qhead_t head
);
    import lzwsc_pkg::*;

    in_item_t   q_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    // no intake while the dictionary is being cleared
    assign data_chan.ready = (cnt_reg != 2'd2) && !hold;
    assign push = data_chan.valid && data_chan.ready;

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= data_chan.payload;
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_reg];
endmodule

// ===== src/lzwsc_back.sv =====
// execution side: dictionary lookup, insert, phrase tracking and byte emit
// depends on lzwsc_pkg, lzwsc_chan_if and lzwsc_hash
module lzwsc_back #(
    parameter int DICT_CAPACITY = 65536,
    parameter int HASH_SLOTS    = 131072
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lzwsc_pkg::qhead_t head,
    output logic              pop,
    output logic              clearing,
    lzwsc_chan_if.source      code_chan
);
    import lzwsc_pkg::*;

    localparam int SLOT_W  = $clog2(HASH_SLOTS);
    localparam int ENTRY_W = 1 + KEY_W + CODE_W;
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(HASH_SLOTS - 1);
    localparam logic [CODE_W-1:0] LIMIT =
        CODE_W'((DICT_CAPACITY > 4194303) ? 4194303 : DICT_CAPACITY);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;

    logic [ENTRY_W-1:0] mem [HASH_SLOTS];
    logic [ENTRY_W-1:0] ent_reg;

    logic [2:0]        state_reg, state_next;
    logic              active_reg, active_next;
    logic [1:0]        cls_reg, cls_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [7:0]        fc_reg, fc_next;
    logic [7:0]        sc_reg, sc_next;
    logic [CODE_W-1:0] next_code_reg, next_code_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] h_reg, h_next;
    logic [SLOT_W-1:0] n_reg, n_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [7:0]        buf_b_reg [4];
    logic [7:0]        buf_b_next [4];
    logic [2:0]        buf_n_reg, buf_n_next;
    logic [1:0]        buf_i_reg, buf_i_next;
    logic              buf_done_reg, buf_done_next;

    logic               we;
    logic [SLOT_W-1:0]  wa;
    logic [ENTRY_W-1:0] wd;
    logic               hash_start, hash_done;
    logic [SLOT_W-1:0]  hash_slot;
    logic [KEY_W-1:0]   key_comb;
    logic               out_last;

    lzwsc_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_comb),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    always_comb
    begin
        logic [PARENT_W-1:0] parent;
        parent = (cls_reg == CLS_ONE) ? (LITERAL_PARENT | {15'd0, fc_reg})
                                      : {1'b0, code_reg & CODE_CEILING};
        key_comb = {parent, head.item.data_byte};
    end

    assign out_last = ({1'b0, buf_i_reg} + 3'd1) == buf_n_reg;

    always_comb
    begin
        emit_t             ea, eb;
        logic              use_a, use_b, finish;
        logic [1:0]        na, nb;
        logic [1:0]        ib;
        logic              ent_valid, hit, empty;
        logic [1:0]        cls_new;
        logic [7:0]        sc_new;
        state_next     = state_reg;
        active_next    = active_reg;
        cls_next       = cls_reg;
        code_next      = code_reg;
        fc_next        = fc_reg;
        sc_next        = sc_reg;
        next_code_next = next_code_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        h_next         = h_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        buf_b_next     = buf_b_reg;
        buf_n_next     = buf_n_reg;
        buf_i_next     = buf_i_reg;
        buf_done_next  = buf_done_reg;
        we             = 1'b0;
        wa             = h_reg;
        wd             = '0;
        hash_start     = 1'b0;
        pop            = 1'b0;
        ea             = '0;
        eb             = '0;
        use_a          = 1'b0;
        use_b          = 1'b0;
        finish         = 1'b0;
        na             = 2'd0;
        nb             = 2'd0;
        ib             = 2'd0;
        ent_valid      = ent_reg[ENTRY_W-1];
        hit            = ent_valid && (ent_reg[ENTRY_W-2 -: KEY_W] == key_reg);
        empty          = !ent_valid;
        cls_new        = CLS_LONG;
        sc_new         = sc_reg;

        // output register drains one byte per taken item
        if (code_chan.valid && code_chan.ready)
        begin
            if (out_last)
            begin
                buf_n_next = 3'd0;
                buf_i_next = 2'd0;
            end
            else
                buf_i_next = buf_i_reg + 2'd1;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wa = clr_reg;
                wd = '0;
                if (clr_reg == SLOT_MAX)
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (head.valid && (buf_n_reg == 3'd0))
                begin
                    pop       = 1'b1;
                    byte_next = head.item.data_byte;
                    last_next = head.item.end_of_stream;
                    if (!active_reg)
                    begin
                        active_next = 1'b1;
                        cls_next    = CLS_ONE;
                        code_next   = '0;
                        fc_next     = head.item.data_byte;
                        sc_next     = '0;
                        if (head.item.end_of_stream)
                        begin
                            ea     = phrase_bytes(CLS_ONE, head.item.data_byte, 8'd0, '0);
                            use_a  = 1'b1;
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        key_next   = key_comb;
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    h_next     = hash_slot;
                    n_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!empty && !hit && (n_reg != SLOT_MAX))
                begin
                    // linear probe to the next slot
                    h_next     = (h_reg == SLOT_MAX) ? '0 : h_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (hit)
                begin
                    // phrase grows
                    if (cls_reg == CLS_ONE)
                    begin
                        cls_new = CLS_TWO;
                        sc_new  = byte_reg;
                    end
                    cls_next   = cls_new;
                    sc_next    = sc_new;
                    code_next  = ent_reg[CODE_W-1:0];
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        ea     = phrase_bytes(cls_new, fc_reg, sc_new, ent_reg[CODE_W-1:0]);
                        use_a  = 1'b1;
                        finish = 1'b1;
                    end
                end
                else
                begin
                    // unknown extension: enter it if there is room, emit the phrase
                    if (empty && (next_code_reg < LIMIT))
                    begin
                        we             = 1'b1;
                        wa             = h_reg;
                        wd             = {1'b1, key_reg, next_code_reg};
                        next_code_next = next_code_reg + 1'b1;
                    end
                    ea          = phrase_bytes(cls_reg, fc_reg, sc_reg, code_reg);
                    use_a       = 1'b1;
                    cls_next    = CLS_ONE;
                    code_next   = '0;
                    fc_next     = byte_reg;
                    sc_next     = '0;
                    state_next  = S_IDLE;
                    if (last_reg)
                    begin
                        eb     = phrase_bytes(CLS_ONE, byte_reg, 8'd0, '0);
                        use_b  = 1'b1;
                        finish = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // end of stream: back to the reset condition, then clear the dictionary
        if (finish)
        begin
            active_next    = 1'b0;
            cls_next       = CLS_NONE;
            code_next      = '0;
            fc_next        = '0;
            sc_next        = '0;
            next_code_next = '0;
            clr_next       = '0;
            state_next     = S_CLEAR;
        end

        if (use_a || use_b)
        begin
            na = use_a ? ea.n : 2'd0;
            nb = use_b ? eb.n : 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                ib = 2'(i) - na;
                if (3'(i) < {1'b0, na})
                    buf_b_next[i] = ea.b[2'(i)];
                else if (ib < 2'd3)
                    buf_b_next[i] = eb.b[ib];
                else
                    buf_b_next[i] = 8'd0;
            end
            buf_n_next    = {1'b0, na} + {1'b0, nb};
            buf_i_next    = 2'd0;
            buf_done_next = finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            active_reg    <= 1'b0;
            cls_reg       <= CLS_NONE;
            code_reg      <= '0;
            fc_reg        <= '0;
            sc_reg        <= '0;
            next_code_reg <= '0;
            buf_n_reg     <= 3'd0;
            buf_i_reg     <= 2'd0;
            buf_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            active_reg    <= active_next;
            cls_reg       <= cls_next;
            code_reg      <= code_next;
            fc_reg        <= fc_next;
            sc_reg        <= sc_next;
            next_code_reg <= next_code_next;
            buf_n_reg     <= buf_n_next;
            buf_i_reg     <= buf_i_next;
            buf_done_reg  <= buf_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        key_reg   <= key_next;
        h_reg     <= h_next;
        n_reg     <= n_next;
        buf_b_reg <= buf_b_next;
    end

    // dictionary memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        ent_reg <= mem[h_reg];
    end

    assign clearing                     = (state_reg == S_CLEAR);
    assign code_chan.valid              = (buf_n_reg != 3'd0);
    assign code_chan.payload.out_byte   = buf_b_reg[buf_i_reg];
    assign code_chan.payload.run_last   = out_last;
    assign code_chan.payload.stream_done = buf_done_reg && out_last;
endmodule

// ===== src/lzw_stream_compressor.sv =====
// a byte that starts a phrase is taken up directly; any other byte passes through dispatch,
// the hash multiply and modulo pipeline and a dictionary read and compare per probe
// items go through one at a time: a new one is taken only when the back is idle and its
// output bytes are drained; the hash pipeline and the dictionary read loop set the pace
// reset: async active low; the dictionary is then cleared one slot after another,
// and again after every end of stream, with input ready held low meanwhile
module lzw_stream_compressor #(
    parameter int DICT_CAPACITY = 65536,
    parameter int HASH_SLOTS    = 131072
) (
    input  logic         clk,
    input  logic         rst_n,
    lzwsc_chan_if.sink   data_chan,
    lzwsc_chan_if.source code_chan
);
    import lzwsc_pkg::*;

    // queue head from front to back, and the clear status going the other way
    qhead_t head;
    logic   pop;
    logic   clearing;

    // front: takes items from the input channel into a short queue
    lzwsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_chan (data_chan),
        .hold      (clearing),
        .pop       (pop),
        .head      (head)
    );

    // back: hashed dictionary walk and the output byte register
    lzwsc_back #(
        .DICT_CAPACITY (DICT_CAPACITY),
        .HASH_SLOTS    (HASH_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .code_chan (code_chan)
    );
endmodule

// ===== src/lzwsc_checker.sv =====
// port level checks for the lzw stream compressor, bound to the top level
// depends on lzw_stream_compressor_assert.svh
`include "lzw_stream_compressor_assert.svh"

module lzwsc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_run_last,
    input logic out_done
);
    // a waiting output item stays offered
    `LZW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // the final byte of a stream is also the last byte of its item
    `LZW_ASSERT_NOW(a_done_last, out_valid && out_done, out_run_last)
    // input ready is expected low once the final byte of a stream is taken
    `LZW_ASSERT_NEXT(a_clear_after_done, out_valid && out_ready && out_done, !in_ready)
endmodule

bind lzw_stream_compressor lzwsc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (data_chan.ready),
    .out_valid    (code_chan.valid),
    .out_ready    (code_chan.ready),
    .out_run_last (code_chan.payload.run_last),
    .out_done     (code_chan.payload.stream_done)
);

// ===== tb/tb.sv =====
// self-checking testbench for lzw_stream_compressor: byte streams in, checked output bytes out
// depends on lzwsc_pkg, lzwsc_chan_if and the compressor rtl
`timescale 1ns / 1ps

module tb;
    import lzwsc_pkg::*;

    // small dictionary so that a few hundred bytes can fill it and the clearing pass is short
    localparam int DICT_CAP   = 256;
    localparam int SLOTS      = 512;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    logic clk;
    logic rst_n;

    lzwsc_chan_if #(.T(in_item_t))  data_chan ();
    lzwsc_chan_if #(.T(out_item_t)) code_chan ();

    lzw_stream_compressor #(
        .DICT_CAPACITY (DICT_CAP),
        .HASH_SLOTS    (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_chan (data_chan),
        .code_chan (code_chan)
    );

    // predicts the compressed bytes of every accepted input byte and checks the output
    class lzw_scoreboard;
        bit              slot_used [SLOTS];
        logic [30:0]     slot_key  [SLOTS];
        int unsigned     slot_code [SLOTS];
        bit              active;
        logic [1:0]      len_cls;
        int unsigned     cur_code;
        logic [7:0]      fc;
        logic [7:0]      sc;
        int unsigned     next_code;
        out_item_t       staged[$];
        out_item_t       pending[$];
        int              errors;

        function new();
            errors = 0;
            clear_dict();
        endfunction

        function void clear_dict();
            foreach (slot_used[i])
            begin
                slot_used[i] = 0;
            end
            active    = 0;
            len_cls   = CLS_NONE;
            cur_code  = 0;
            fc        = '0;
            sc        = '0;
            next_code = 0;
        endfunction

        function void stage(logic [7:0] b);
            out_item_t o;
            o.out_byte    = b;
            o.run_last    = 1'b0;
            o.stream_done = 1'b0;
            staged.insert(staged.size(), o);
        endfunction

        function void start_phrase(logic [7:0] b);
            active   = 1;
            len_cls  = CLS_ONE;
            cur_code = 0;
            fc       = b;
            sc       = '0;
        endfunction

        function void emit_phrase();
            logic [23:0] v;
            if (len_cls != CLS_LONG)
            begin
                stage(fc);
                if (len_cls == CLS_TWO)
                    stage(sc);
            end
            else if (cur_code > 16383)
            begin
                v = 24'((cur_code & 32'h3FFFFF) | 32'hC00000);
                stage(v[23:16]);
                stage(v[15:8]);
                stage(v[7:0]);
            end
            else
            begin
                v = 24'(cur_code | 32'h008000);
                stage(v[15:8]);
                stage(v[7:0]);
            end
        endfunction

        function void note_input(in_item_t it);
            logic [22:0] parent;
            logic [30:0] key;
            logic [31:0] prod;
            int unsigned h;
            bit          room;
            staged.delete();
            if (!active)
            begin
                start_phrase(it.data_byte);
            end
            else
            begin
                parent = (len_cls == CLS_ONE) ? (LITERAL_PARENT | {15'd0, fc})
                                              : {1'b0, 22'(cur_code)};
                key  = {parent, it.data_byte};
                prod = {1'b0, key} * HASH_MULT;
                h    = prod % SLOTS;
                room = 0;
                // linear probe for the key or the first free slot
                for (int n = 0; n < SLOTS; n++)
                begin
                    if (!slot_used[h] || slot_key[h] == key)
                    begin
                        room = 1;
                        break;
                    end
                    h = (h + 1) % SLOTS;
                end
                if (room && slot_used[h])
                begin
                    cur_code = slot_code[h];
                    if (len_cls == CLS_ONE)
                    begin
                        sc      = it.data_byte;
                        len_cls = CLS_TWO;
                    end
                    else
                    begin
                        len_cls = CLS_LONG;
                    end
                end
                else
                begin
                    if (room && next_code < DICT_CAP)
                    begin
                        slot_used[h] = 1;
                        slot_key[h]  = key;
                        slot_code[h] = next_code;
                        next_code++;
                    end
                    emit_phrase();
                    start_phrase(it.data_byte);
                end
            end
            if (it.end_of_stream)
            begin
                emit_phrase();
                staged[staged.size()-1].stream_done = 1'b1;
                clear_dict();
            end
            if (staged.size() > 0)
                staged[staged.size()-1].run_last = 1'b1;
            foreach (staged[i])
            begin
                pending.insert(pending.size(), staged[i]);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output byte %02h last %0b done %0b",
                             got.out_byte, got.run_last, got.stream_done);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b, done exp %0b got %0b",
                             want.out_byte, got.out_byte, want.run_last, got.run_last,
                             want.stream_done, got.stream_done);
            end
        endfunction
    endclass

    lzw_scoreboard sb;
    int  idle_cycles;
    int  outputs_seen;
    bit  tail_phase;
    bit  held_long;

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // monitor and watchdog, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (data_chan.valid && data_chan.ready)
                sb.note_input(data_chan.payload);
            if (code_chan.valid && code_chan.ready)
            begin
                sb.check_result(code_chan.payload);
                outputs_seen++;
            end
            if ((data_chan.valid && data_chan.ready) || (code_chan.valid && code_chan.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off so the block backs up into its input
    initial
    begin
        code_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_long && outputs_seen >= 30)
            begin
                code_chan.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                held_long = 1;
                code_chan.ready = 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 7) == 0)
            begin
                code_chan.ready = 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
            else
            begin
                code_chan.ready = 1'b1;
            end
        end
    end

    // one input item; called just after a falling edge, returns just after one
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (!tail_phase && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 17)) @(negedge clk);
        data_chan.valid                 = 1'b1;
        data_chan.payload.data_byte     = b;
        data_chan.payload.end_of_stream = eos;
        do
            @(posedge clk);
        while (!data_chan.ready);
        @(negedge clk);
        data_chan.valid = 1'b0;
    endtask

    // a stream mostly from a three-byte alphabet so phrases grow into coded ones
    task automatic send_stream(input int len, input int wide_pct, input int tail_from);
        logic [7:0] alpha [3];
        logic [7:0] b;
        foreach (alpha[i])
        begin
            alpha[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < len; i++)
        begin
            if (i >= tail_from)
                tail_phase = 1;
            if ($urandom_range(0, 99) < wide_pct)
                b = 8'($urandom_range(0, 255));
            else
                b = alpha[$urandom_range(0, 2)];
            send_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        int random_sent;
        sb           = new();
        idle_cycles  = 0;
        outputs_seen = 0;
        tail_phase   = 0;
        held_long    = 0;
        random_sent  = 0;
        data_chan.valid   = 1'b0;
        data_chan.payload = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-byte stream: first byte is also the last
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte stream, emitted as two literals
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // repeating pair builds phrases long enough to go out as codes
        for (int i = 0; i < 9; i++)
        begin
            send_byte((i % 2) ? 8'h42 : 8'h41, i == 8);
        end
        // run of one value, bit patterns on both halves
        for (int i = 0; i < 7; i++)
        begin
            send_byte(8'h00, 1'b0);
        end
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);

        // short random streams
        while (random_sent < 45)
        begin
            int len;
            len = $urandom_range(1, 20);
            send_stream(len, 25, len + 1);
            random_sent += len;
        end
        // one long wide stream fills the dictionary, then the tail runs with no idling
        send_stream(275, 95, 235);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
